[hw/rtl/oqwr_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helpers of the ordered queue with removal.
// Used by the channel interfaces, the cell, the controller and the top level.
package oqwr_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int CAP_W       = 5;
    localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int ID_W        = 16;
    localparam int CNT_OUT_W   = 5;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    typedef logic [ID_W-1:0]      t_id;
    typedef logic [CNT_W-1:0]     t_count;
    typedef logic [CMP_W-1:0]     t_cmp;
    typedef logic [CAP_W-1:0]     t_cap;
    typedef logic [CNT_OUT_W-1:0] t_count_out;
    typedef logic [1:0]           t_cmd;
    typedef logic [1:0]           t_status;

    // Command codes; the fourth code is a no-op
    localparam t_cmd CMD_PUSH   = 2'd0;
    localparam t_cmd CMD_POP    = 2'd1;
    localparam t_cmd CMD_REMOVE = 2'd2;

    // Status codes
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_FULL      = 2'd1;
    localparam t_status ST_EMPTY     = 2'd2;
    localparam t_status ST_NOT_FOUND = 2'd3;

    // Register byte offset bit that selects beyond the capacity register
    localparam int REG_SEL_BIT = 2;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic   capture;   // latch per-cell match against cmp_id
        t_id    cmp_id;    // identifier compared on capture
        logic   push;      // write wr_id at the tail cell
        logic   pop;       // every cell takes its right neighbor
        logic   remove;    // cells at or after the first match take neighbor
        t_id    wr_id;     // identifier written on push
        t_count count;     // occupancy before the step
    } t_cell_ctl;

    // Fit the occupancy to the result field width
    function automatic t_count_out count_out(input t_count c);
        logic [31:0] w;
        w = 32'(c);
        return w[CNT_OUT_W-1:0];
    endfunction

endpackage

[hw/rtl/oqwr_req_if.sv]
`timescale 1ns / 1ps
// Request channel of the ordered queue: valid/ready plus command and identifier.
// Depends on oqwr_pkg.
interface oqwr_req_if import oqwr_pkg::*; ();
    logic valid;
    logic ready;
    t_cmd command;
    t_id  entry_id;

    modport source (output valid, output command, output entry_id, input ready);
    modport sink   (input valid, input command, input entry_id, output ready);
endinterface

[hw/rtl/oqwr_rsp_if.sv]
`timescale 1ns / 1ps
// Result channel of the ordered queue: valid/ready plus status, head and count.
// Depends on oqwr_pkg.
interface oqwr_rsp_if import oqwr_pkg::*; ();
    logic       valid;
    logic       ready;
    t_status    status;
    t_id        popped_id;
    t_count_out count_after;

    modport source (output valid, output status, output popped_id, output count_after,
                    input ready);
    modport sink   (input valid, input status, input popped_id, input count_after,
                    output ready);
endinterface

[hw/rtl/oqwr_cell.sv]
`timescale 1ns / 1ps
// One queue cell: holds one identifier, compares it, and shifts from its neighbor.
// Depends on oqwr_pkg.
module oqwr_cell import oqwr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_count    i_index,
    input  t_id       i_next_data,
    input  logic      i_prev_hit,
    output logic      o_hit,
    output t_id       o_data
);

    t_id  r_data;
    t_id  n_data;
    logic r_match;
    logic w_occupied;
    logic w_at_or_after;

    assign w_occupied    = i_index < i_ctl.count;
    assign w_at_or_after = i_prev_hit | r_match;

    // Pass the first-match chain to the right
    assign o_hit  = w_at_or_after;
    assign o_data = r_data;

    // Latch the compare result for the remove that follows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctl.capture) begin
            r_match <= w_occupied && (r_data == i_ctl.cmp_id);
        end
    end

    // Select the cell's next contents
    always_comb begin
        n_data = r_data;
        if (i_ctl.pop || (i_ctl.remove && w_at_or_after)) begin
            n_data = i_next_data;
        end else if (i_ctl.push && (i_index == i_ctl.count)) begin
            n_data = i_ctl.wr_id;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

[hw/rtl/oqwr_ctrl.sv]
`timescale 1ns / 1ps
// Queue controller: request handshake, occupancy, status and the result register.
// Depends on oqwr_pkg, oqwr_req_if and oqwr_rsp_if.
module oqwr_ctrl import oqwr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    oqwr_req_if.sink    i_req,
    oqwr_rsp_if.source  o_rsp,
    input  t_cmp        i_cap_eff,
    input  logic        i_found,
    input  t_id         i_head,
    output t_cell_ctl   o_ctl
);

    t_state     r_state;
    t_state     n_state;
    t_cmd       r_cmd;
    t_id        r_id;
    t_count     r_count;
    t_count     n_count;
    logic       r_out_valid;
    t_status    r_status;
    t_status    n_status;
    t_id        r_popped;
    t_id        n_popped;
    t_count_out r_count_after;
    logic       w_accept;
    logic       w_exec_fire;
    logic       w_empty;
    logic       w_full;

    assign w_empty = (r_count == '0);
    assign w_full  = t_cmp'(r_count) >= i_cap_eff;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_req.valid) n_state = S_EXEC;
            S_EXEC: if (w_exec_fire) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs: handshake, cell commands, status and next occupancy
    always_comb begin
        i_req.ready  = (r_state == S_IDLE);
        w_accept     = (r_state == S_IDLE) && i_req.valid;
        w_exec_fire  = (r_state == S_EXEC) && (!r_out_valid || o_rsp.ready);
        o_ctl        = '0;
        o_ctl.capture = w_accept;
        o_ctl.cmp_id  = i_req.entry_id;
        o_ctl.wr_id   = r_id;
        o_ctl.count   = r_count;
        n_status     = ST_OK;
        n_popped     = '0;
        n_count      = r_count;
        if (r_state == S_EXEC) begin
            unique case (r_cmd)
                CMD_PUSH: begin
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        o_ctl.push = w_exec_fire;
                        n_count    = r_count + 1'b1;
                    end
                end
                CMD_POP: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        o_ctl.pop = w_exec_fire;
                        n_popped  = i_head;
                        n_count   = r_count - 1'b1;
                    end
                end
                CMD_REMOVE: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end else if (!i_found) begin
                        n_status = ST_NOT_FOUND;
                    end else begin
                        o_ctl.remove = w_exec_fire;
                        n_count      = r_count - 1'b1;
                    end
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_exec_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the request and the result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_req.command;
            r_id  <= i_req.entry_id;
        end
        if (w_exec_fire) begin
            r_status      <= n_status;
            r_popped      <= n_popped;
            r_count_after <= count_out(n_count);
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.popped_id   = r_popped;
    assign o_rsp.count_after = r_count_after;

    // Occupancy never passes the cell count
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        t_cmp'(r_count) <= t_cmp'(QUEUE_DEPTH))
        else $error("occupancy beyond queue depth");

    // A granted push grows the queue by one
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.push |=> (r_count == t_count'($past(r_count) + 1'b1)))
        else $error("push did not advance occupancy");

    // A granted pop or remove shrinks the queue by one
    a_drop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.pop || o_ctl.remove) |=> (r_count == t_count'($past(r_count) - 1'b1)))
        else $error("pop or remove did not reduce occupancy");

    // Every executed request leaves a result waiting
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exec_fire |=> (o_rsp.valid && (o_rsp.count_after == count_out(r_count))))
        else $error("result not loaded after execution");

endmodule

[hw/rtl/ordered_queue_with_removal.sv]
`timescale 1ns / 1ps
// Ordered queue of 16-bit identifiers with push, pop and remove-by-value. In the
// cycle a request is accepted, every cell compares its identifier against the
// request; in the execute state that follows, the row of cells shifts or loads
// and the result is written to the output register. A new request is taken only
// once the execute state is done, so requests do not overlap; the execute state
// waits only while the previous result still sits unread in the output register.
// Capacity is set through the APB register at offset 0 and is clamped to the
// cell count.
// Depends on oqwr_pkg, oqwr_req_if, oqwr_rsp_if, oqwr_cell and oqwr_ctrl.
module ordered_queue_with_removal import oqwr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    oqwr_req_if.sink           i_req,
    oqwr_rsp_if.source         o_rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cap      r_cap;
    t_cmp      w_cap_ext;
    t_cmp      w_cap_eff;
    t_cell_ctl w_ctl;
    t_id       w_data [0:QUEUE_DEPTH];
    logic      w_hit  [0:QUEUE_DEPTH];
    logic      w_cap_sel;

    // Capacity register
    assign pready    = 1'b1;
    assign w_cap_sel = !paddr[REG_SEL_BIT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= '0;
        end else if (psel && penable && pwrite && pready && w_cap_sel) begin
            r_cap <= pwdata[CAP_W-1:0];
        end
    end

    assign prdata = w_cap_sel ? PDATA_W'(r_cap) : '0;

    // Clamp the capacity to the cell count
    assign w_cap_ext = t_cmp'(r_cap);
    assign w_cap_eff = (w_cap_ext > t_cmp'(QUEUE_DEPTH)) ? t_cmp'(QUEUE_DEPTH) : w_cap_ext;

    oqwr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .i_cap_eff (w_cap_eff),
        .i_found   (w_hit[QUEUE_DEPTH]),
        .i_head    (w_data[0]),
        .o_ctl     (w_ctl)
    );

    // Row of cells; the last cell shifts in zero
    assign w_hit[0]            = 1'b0;
    assign w_data[QUEUE_DEPTH] = '0;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        oqwr_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_index     (t_count'(g)),
            .i_next_data (w_data[g+1]),
            .i_prev_hit  (w_hit[g]),
            .o_hit       (w_hit[g+1]),
            .o_data      (w_data[g])
        );
    end

endmodule
